[rtl/core/slt_pkg.sv]
// Shared command and status codes for the sorted list table.
`default_nettype none

package slt_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  localparam int unsigned CountOutW = 7;

endpackage

`default_nettype wire

[rtl/core/sorted_list_table.sv]
// Sorted list table: bounded ascending multiset of signed 32-bit values.
`default_nettype none

// Sorted multiset of signed 32-bit values held in ascending order in a
// single-port-write RAM of CAPACITY words. An item (command, value) is taken
// when start_i is high and busy_o is low; busy_o stays high until the result
// has been shown. The result appears for exactly one cycle with done_o high and
// must be taken then: there is no backpressure on the result side.
// Steps per item, with N entries stored: take the item, scan the N entries
// of the RAM (one read per cycle, registered read data), a decision step,
// then for insert and delete a shift pass that moves the entries after the
// insertion point or the hole one slot over, and last the result strobe.
// Worst case is a delete of the smallest entry from a full store: every
// entry is read once in the scan and all but one once more in the shift,
// since the single RAM port pair serves both passes.
// Clear only drops the count; the RAM contents are left as they are.
module sorted_list_table import slt_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output      logic                 busy_o,
  input  wire logic [1:0]           command_i,
  input  wire logic signed [31:0]   value_i,
  output      logic                 done_o,
  output      logic [1:0]           status_o,
  output      logic                 found_o,
  output      logic [CountOutW-1:0] entry_count_o,
  output      logic                 is_empty_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_q, state_d;

  // entry RAM
  logic [31:0]     mem_q [CAPACITY];
  logic [31:0]     rd_data_q;
  logic [IdxW-1:0] rd_addr;
  logic            we;
  logic [IdxW-1:0] wa;
  logic [31:0]     wd;

  // item payload
  logic [1:0]         cmd_q;
  logic signed [31:0] val_q;

  // control and status
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] rd_ptr_q, rd_ptr_d;
  logic            chk_vld_q, chk_vld_d;
  logic [IdxW-1:0] chk_idx_q, chk_idx_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic            at_set_q, at_set_d;
  logic [CntW-1:0] at_q, at_d;
  logic [CntW-1:0] sh_left_q, sh_left_d;
  logic [IdxW-1:0] sh_src_q, sh_src_d;
  logic            pend_vld_q, pend_vld_d;
  logic [IdxW-1:0] pend_dst_q, pend_dst_d;
  logic [1:0]      status_q, status_d;

  logic              accept;
  logic              is_match;
  logic              is_less;
  logic [CntW-1:0]   fill_m1;
  logic [IdxW:0]     pos_p1;
  logic [CntW+6:0]   fill_ext;

  assign accept   = start_i && !busy_o;
  assign is_match = (rd_data_q == val_q);
  assign is_less  = ($signed(rd_data_q) < val_q);
  assign fill_m1  = fill_q - 1'b1;
  assign pos_p1   = {1'b0, pos_q} + 1'b1;
  assign fill_ext = {7'b0, fill_q};

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    rd_ptr_d   = rd_ptr_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = chk_idx_q;
    found_d    = found_q;
    pos_d      = pos_q;
    at_set_d   = at_set_q;
    at_d       = at_q;
    sh_left_d  = sh_left_q;
    sh_src_d   = sh_src_q;
    pend_vld_d = 1'b0;
    pend_dst_d = pend_dst_q;
    status_d   = status_q;
    rd_addr    = rd_ptr_q[IdxW-1:0];
    we         = 1'b0;
    wa         = pend_dst_q;
    wd         = rd_data_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rd_ptr_d = '0;
          found_d  = 1'b0;
          at_set_d = 1'b0;
          at_d     = fill_q;       // insert at the end unless an equal or larger entry shows
          state_d  = (fill_q == '0) ? S_DECIDE : S_SCAN;
        end
      end

      S_SCAN: begin
        // read one entry per cycle, compare the one read last cycle
        if (rd_ptr_q < fill_q) begin
          rd_addr   = rd_ptr_q[IdxW-1:0];
          rd_ptr_d  = rd_ptr_q + 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = rd_ptr_q[IdxW-1:0];
        end
        if (chk_vld_q) begin
          if (is_match && !found_q) begin
            found_d = 1'b1;
            pos_d   = chk_idx_q;
          end
          if (!is_less && !at_set_q) begin
            at_set_d = 1'b1;
            at_d     = CntW'(chk_idx_q);
          end
          if (CntW'(chk_idx_q) == fill_m1) begin
            chk_vld_d = 1'b0;
            state_d   = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        status_d = ST_OK;
        state_d  = S_DONE;
        case (cmd_q)
          CMD_INSERT: begin
            if (fill_q >= CntW'(CAPACITY)) begin
              status_d = ST_FULL;
            end else begin
              sh_left_d = fill_q - at_q;
              sh_src_d  = fill_m1[IdxW-1:0];   // move from the top down
              state_d   = S_SHIFT;
            end
          end
          CMD_DELETE: begin
            if (found_q) begin
              sh_left_d = fill_m1 - CntW'(pos_q);
              sh_src_d  = pos_p1[IdxW-1:0];    // move from just above the hole up
              state_d   = S_SHIFT;
            end else begin
              status_d = ST_NOTFOUND;
            end
          end
          CMD_QUERY: begin
            status_d = found_q ? ST_OK : ST_NOTFOUND;
          end
          CMD_CLEAR: begin
            fill_d = '0;
          end
          default: begin
            status_d = ST_OK;
          end
        endcase
      end

      S_SHIFT: begin
        // read source now, write it one slot over next cycle
        if (sh_left_q != '0) begin
          rd_addr    = sh_src_q;
          sh_left_d  = sh_left_q - 1'b1;
          pend_vld_d = 1'b1;
          if (cmd_q == CMD_INSERT) begin
            pend_dst_d = sh_src_q + 1'b1;
            sh_src_d   = sh_src_q - 1'b1;
          end else begin
            pend_dst_d = sh_src_q - 1'b1;
            sh_src_d   = sh_src_q + 1'b1;
          end
        end
        if (pend_vld_q) begin
          we = 1'b1;
          wa = pend_dst_q;
          wd = rd_data_q;
        end else if (sh_left_q == '0) begin
          if (cmd_q == CMD_INSERT) begin
            we     = 1'b1;
            wa     = at_q[IdxW-1:0];
            wd     = val_q;
            fill_d = fill_q + 1'b1;
          end else begin
            fill_d = fill_q - 1'b1;
          end
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fill_q     <= '0;
      rd_ptr_q   <= '0;
      chk_vld_q  <= 1'b0;
      chk_idx_q  <= '0;
      found_q    <= 1'b0;
      pos_q      <= '0;
      at_set_q   <= 1'b0;
      at_q       <= '0;
      sh_left_q  <= '0;
      sh_src_q   <= '0;
      pend_vld_q <= 1'b0;
      pend_dst_q <= '0;
      status_q   <= ST_OK;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      rd_ptr_q   <= rd_ptr_d;
      chk_vld_q  <= chk_vld_d;
      chk_idx_q  <= chk_idx_d;
      found_q    <= found_d;
      pos_q      <= pos_d;
      at_set_q   <= at_set_d;
      at_q       <= at_d;
      sh_left_q  <= sh_left_d;
      sh_src_q   <= sh_src_d;
      pend_vld_q <= pend_vld_d;
      pend_dst_q <= pend_dst_d;
      status_q   <= status_d;
    end
  end

  // item payload capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      val_q <= value_i;
    end
  end

  // entry RAM: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = (state_q == S_DONE);
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign entry_count_o = fill_ext[CountOutW-1:0];
  assign is_empty_o    = (fill_q == '0);

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the sorted list table: directed and random items, shadow model.
`timescale 1ns / 1ps

module testbench;
  import slt_pkg::*;

  localparam int unsigned CAPACITY = 64;
  // The slowest items and the longest sender gaps together stay well below
  // this limit, so it leaves a wide margin.
  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned DrainCycles = 2 * CAPACITY + 8;
  localparam int unsigned RandomItems = 1150;
  localparam int unsigned MaxReports = 10;

  // One expected reply per accepted item.
  typedef struct packed {
    logic [1:0]           status;
    logic                 found;
    logic [CountOutW-1:0] count;
    logic                 is_empty;
  } reply_t;

  // Shadow of the stored multiset. It predicts every reply and checks the
  // replies in arrival order.
  class list_tracker;
    logic signed [31:0] shadow_entries[$];
    reply_t             pending_replies[$];
    int unsigned        replies_seen;
    int unsigned        mismatches;
    bit                 failed;

    // Apply one accepted item to the shadow and queue the reply it yields.
    function void apply_item(cmd_e cmd, logic signed [31:0] value);
      int     hit_pos;
      int     at;
      reply_t exp;
      hit_pos = -1;
      foreach (shadow_entries[i]) begin
        if (hit_pos < 0 && shadow_entries[i] == value) hit_pos = i;
      end
      exp.found  = (hit_pos >= 0);
      exp.status = ST_OK;
      case (cmd)
        CMD_INSERT: begin
          if (shadow_entries.size() >= CAPACITY) begin
            exp.status = ST_FULL;
          end else begin
            // new value goes after every smaller entry, ahead of equal ones
            at = 0;
            while (at < shadow_entries.size() && shadow_entries[at] < value) at++;
            shadow_entries.insert(at, value);
          end
        end
        CMD_DELETE: begin
          if (exp.found) shadow_entries.delete(hit_pos);
          else exp.status = ST_NOTFOUND;
        end
        CMD_QUERY: begin
          exp.status = exp.found ? ST_OK : ST_NOTFOUND;
        end
        default: begin
          shadow_entries.delete();
        end
      endcase
      exp.count    = CountOutW'(shadow_entries.size());
      exp.is_empty = (shadow_entries.size() == 0);
      pending_replies.push_back(exp);
    endfunction

    // Compare one strobed reply with the oldest prediction.
    function void match_reply(logic [1:0] status, logic found,
                              logic [CountOutW-1:0] count, logic is_empty);
      reply_t exp;
      replies_seen++;
      if (pending_replies.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= MaxReports)
          $display("reply %0d arrived with no item outstanding", replies_seen);
      end else begin
        exp = pending_replies.pop_front();
        if (status !== exp.status || found !== exp.found ||
            count !== exp.count || is_empty !== exp.is_empty) begin
          failed = 1'b1;
          mismatches++;
          // fields shown as status/found/count/empty
          if (mismatches <= MaxReports)
            $display("reply %0d: expected %0d/%0b/%0d/%0b, got %0d/%0b/%0d/%0b",
                     replies_seen, exp.status, exp.found, exp.count, exp.is_empty,
                     status, found, count, is_empty);
        end
      end
    endfunction
  endclass

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 start_i   = 1'b0;
  logic [1:0]           command_i = CMD_QUERY;
  logic signed [31:0]   value_i   = '0;
  logic                 busy_o;
  logic                 done_o;
  logic [1:0]           status_o;
  logic                 found_o;
  logic [CountOutW-1:0] entry_count_o;
  logic                 is_empty_o;

  list_tracker tracker = new();
  int unsigned cycle_count = 0;

  sorted_list_table #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .command_i    (command_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .found_o      (found_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o)
  );

  always #1 clk_i = ~clk_i;

  // Sampling at the edge sees the pre-edge values of every port, so an item
  // taken and a reply strobed at the same edge are both seen correctly. The
  // prediction is queued at the back and the check pops the front.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) tracker.apply_item(cmd_e'(command_i), value_i);
      if (done_o) tracker.match_reply(status_o, found_o, entry_count_o, is_empty_o);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("sorted_list_table: mismatch");
      $finish;
    end
  end

  // Present one item and hold it until the block takes it. With may_idle the
  // sender first drops start for a random gap. A gap of up to one full item
  // time lets the next start land on any phase of the block's work.
  task automatic send_item(cmd_e cmd, logic signed [31:0] value, bit may_idle);
    if (may_idle) begin
      if ($urandom_range(0, 4) == 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, DrainCycles)) @(posedge clk_i);
      end
      while ($urandom_range(0, 99) < 36) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    start_i   <= 1'b1;
    command_i <= cmd;
    value_i   <= value;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // Values are skewed toward stored entries and a narrow band around zero,
  // so that hits, duplicates and deletes of repeated values are frequent.
  // Full-width random values cover every bit.
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] boundary_values[6];
    int                 roll;
    boundary_values = '{32'sh8000_0000, 32'sh8000_0001, 32'sh7fff_fffe,
                        32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff};
    roll = $urandom_range(0, 99);
    if (roll < 30 && tracker.shadow_entries.size() != 0)
      return tracker.shadow_entries[$urandom_range(0, tracker.shadow_entries.size() - 1)];
    if (roll < 55) return $signed($urandom_range(0, 8)) - 32'sd4;
    if (roll < 65) return boundary_values[$urandom_range(0, 5)];
    return $urandom();
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase_left;
    int unsigned kind;
    int unsigned roll;
    cmd_e        cmd;
    bit          may_idle;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty-store cases, extremes, duplicates, first-match delete,
    // clear with membership reported, and alternating bit patterns.
    send_item(CMD_QUERY,  32'sd5, 1'b1);         // absent on empty
    send_item(CMD_DELETE, 32'sd5, 1'b1);         // delete on empty
    send_item(CMD_CLEAR,  32'sd0, 1'b1);         // clear when already empty
    send_item(CMD_INSERT, 32'sd0, 1'b1);
    send_item(CMD_INSERT, 32'sd0, 1'b1);         // duplicate
    send_item(CMD_INSERT, 32'sh8000_0000, 1'b1); // most negative
    send_item(CMD_INSERT, 32'sh7fff_ffff, 1'b1); // most positive
    send_item(CMD_INSERT, -32'sd1, 1'b1);
    send_item(CMD_INSERT, 32'sd1, 1'b1);
    send_item(CMD_QUERY,  32'sd0, 1'b1);
    send_item(CMD_QUERY,  32'sd2, 1'b1);
    send_item(CMD_DELETE, 32'sd0, 1'b1);         // one of the two copies
    send_item(CMD_QUERY,  32'sd0, 1'b1);
    send_item(CMD_DELETE, 32'sd0, 1'b1);
    send_item(CMD_DELETE, 32'sd0, 1'b1);         // now absent
    send_item(CMD_DELETE, 32'sh8000_0000, 1'b1);
    send_item(CMD_DELETE, 32'sh7fff_ffff, 1'b1);
    send_item(CMD_INSERT, 32'sh5555_5555, 1'b1);
    send_item(CMD_INSERT, 32'shaaaa_aaaa, 1'b1);
    send_item(CMD_QUERY,  -32'sd1, 1'b1);
    send_item(CMD_CLEAR,  32'sd1, 1'b1);         // found reported before clear
    send_item(CMD_QUERY,  32'sd1, 1'b1);
    send_item(CMD_INSERT, 32'sd7, 1'b1);
    send_item(CMD_CLEAR,  32'sd9, 1'b1);         // clear with absent value

    // Random phases: grow (fills the store and hits inserts while full),
    // mixed, and shrink. The first phase is always a long growth run.
    sent       = 0;
    phase_left = 110;
    kind       = 0;
    while (sent < RandomItems) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 120);
        kind       = $urandom_range(0, 2);
      end
      roll = $urandom_range(0, 99);
      case (kind)
        0:       cmd = (roll < 85) ? CMD_INSERT : (roll < 93) ? CMD_QUERY :
                       (roll < 99) ? CMD_DELETE : CMD_CLEAR;
        1:       cmd = (roll < 40) ? CMD_INSERT : (roll < 70) ? CMD_DELETE :
                       (roll < 95) ? CMD_QUERY  : CMD_CLEAR;
        default: cmd = (roll < 15) ? CMD_INSERT : (roll < 75) ? CMD_DELETE :
                       (roll < 97) ? CMD_QUERY  : CMD_CLEAR;
      endcase
      // back-to-back stretch with no sender gaps
      may_idle = !(sent >= 500 && sent < 650);
      send_item(cmd, pick_value(), may_idle);
      sent++;
      phase_left--;
    end
    start_i <= 1'b0;

    while (tracker.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (!tracker.failed && tracker.pending_replies.size() == 0) begin
      $display("sorted_list_table: match");
    end else begin
      $display("sorted_list_table: mismatch");
    end
    $finish;
  end

endmodule
